FILE: rtl/core/rgd_pkg.sv
// Shared types and constants for the RDS group decoder
`timescale 1ns / 1ps
package rgd_pkg;

    localparam int NAME_LEN    = 8;
    localparam int TEXT_LEN    = 64;
    localparam int RT_LANES    = 4;
    localparam int RT_ROWS     = TEXT_LEN / RT_LANES;
    localparam int RT_ROW_W    = $clog2(RT_ROWS);
    localparam int RT_LANE_W   = $clog2(RT_LANES);
    localparam int RT_IDX_W    = $clog2(TEXT_LEN);
    localparam int NAME_IDX_W  = $clog2(NAME_LEN);

    localparam logic [1:0] OP_DECODE  = 2'd0;
    localparam logic [1:0] OP_READ_PS = 2'd1;
    localparam logic [1:0] OP_READ_RT = 2'd2;

    localparam logic [4:0] GRP_0A = 5'd0;
    localparam logic [4:0] GRP_0B = 5'd1;
    localparam logic [4:0] GRP_1A = 5'd2;
    localparam logic [4:0] GRP_1B = 5'd3;
    localparam logic [4:0] GRP_2A = 5'd4;
    localparam logic [4:0] GRP_2B = 5'd5;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_NULL = 8'h00;
    localparam logic [1:0] AB_NONE   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] block_a;
        logic [15:0] block_b;
        logic [15:0] block_c;
        logic [15:0] block_d;
        logic [5:0]  read_index;
    } t_in_req;

    typedef struct packed {
        logic [15:0] prog_ident;
        logic        traffic_prog;
        logic [4:0]  prog_type;
        logic [4:0]  group_code;
        logic [7:0]  alt_freq_first;
        logic [7:0]  alt_freq_second;
        logic [4:0]  item_day;
        logic [4:0]  item_hour;
        logic [5:0]  item_minute;
        logic [7:0]  read_char;
    } t_out_req;

    // one row write into the radio-text memory, lane 0 in the low byte
    typedef struct packed {
        logic                      en;
        logic                      fill;
        logic [RT_ROW_W-1:0]       row;
        logic [RT_LANES-1:0]       be;
        logic [RT_LANES*8-1:0]     data;
    } t_rt_wr;

    typedef struct packed {
        logic       hdr_en;
        logic       af_en;
        logic       time_en;
        logic       ps_en;
        logic [1:0] ps_seg;
        t_rt_wr     rt;
    } t_dec;

endpackage

FILE: rtl/core/rgd_in_if.sv
// Request channel into the RDS group decoder
`timescale 1ns / 1ps
interface rgd_in_if;
    import rgd_pkg::*;

    logic    valid;
    logic    ready;
    t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/rgd_out_if.sv
// Result channel out of the RDS group decoder
`timescale 1ns / 1ps
interface rgd_out_if;
    import rgd_pkg::*;

    logic     valid;
    logic     ready;
    t_out_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/rgd_decode.sv
// Group decode: turns one request into store update commands
`timescale 1ns / 1ps
module rgd_decode (
    input  rgd_pkg::t_in_req i_req,
    input  logic [1:0]       i_ab_last,
    output rgd_pkg::t_dec    o_dec
);
    import rgd_pkg::*;

    logic [4:0]  grp;
    logic [15:0] blk_b;
    logic [15:0] blk_c;
    logic [15:0] blk_d;

    assign blk_b = i_req.block_b;
    assign blk_c = i_req.block_c;
    assign blk_d = i_req.block_d;
    assign grp   = blk_b[15:11];

    always_comb begin
        o_dec = '0;
        o_dec.ps_seg = blk_b[1:0];
        o_dec.rt.row = blk_b[RT_ROW_W-1:0];
        if (i_req.opcode == OP_DECODE) begin
            o_dec.hdr_en = 1'b1;
            case (grp)
                GRP_0A: begin
                    o_dec.af_en = 1'b1;
                    o_dec.ps_en = 1'b1;
                end
                GRP_0B: begin
                    o_dec.ps_en = 1'b1;
                end
                GRP_1A, GRP_1B: begin
                    o_dec.time_en = 1'b1;
                end
                GRP_2A: begin
                    o_dec.rt.en   = 1'b1;
                    o_dec.rt.be   = '1;
                    o_dec.rt.data = {blk_d[7:0], blk_d[15:8], blk_c[7:0], blk_c[15:8]};
                end
                GRP_2B: begin
                    // two chars land in one half of row segment/2
                    o_dec.rt.en   = 1'b1;
                    o_dec.rt.row  = {1'b0, blk_b[RT_ROW_W-1:1]};
                    o_dec.rt.be   = blk_b[0] ? 4'b1100 : 4'b0011;
                    o_dec.rt.data = {blk_d[7:0], blk_d[15:8], blk_d[7:0], blk_d[15:8]};
                end
                default: begin
                end
            endcase
            o_dec.rt.fill = o_dec.rt.en && ({1'b0, blk_b[4]} != i_ab_last);
        end
    end

endmodule

FILE: rtl/core/rgd_text_store.sv
// Radio-text store: row memory with per-char valid bits and write forwarding
`timescale 1ns / 1ps
module rgd_text_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rgd_pkg::t_rt_wr                 i_wr,
    input  logic                            i_rd_en,
    input  logic [rgd_pkg::RT_IDX_W-1:0]    i_rd_idx,
    input  logic [rgd_pkg::RT_IDX_W-1:0]    i_cur_idx,
    output logic [7:0]                      o_char
);
    import rgd_pkg::*;

    logic [RT_LANES*8-1:0] r_mem [RT_ROWS];
    logic [RT_LANES*8-1:0] r_rd_data;
    logic [RT_LANES-1:0]   r_fwd_be;
    logic [RT_LANES*8-1:0] r_fwd_data;
    logic [TEXT_LEN-1:0]   r_valid;
    logic [TEXT_LEN-1:0]   n_valid;
    logic [TEXT_LEN-1:0]   set_mask;
    logic [7:0]            r_clear_val;
    logic [RT_LANE_W-1:0]  lane;
    logic [7:0]            mem_char;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int k = 0; k < RT_LANES; k++) begin
                if (i_wr.be[k]) begin
                    r_mem[i_wr.row][k*8 +: 8] <= i_wr.data[k*8 +: 8];
                end
            end
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx[RT_IDX_W-1:RT_LANE_W]];
            // the row being written at this edge is missing from the read
            r_fwd_be   <= (i_wr.en && (i_wr.row == i_rd_idx[RT_IDX_W-1:RT_LANE_W]))
                          ? i_wr.be : '0;
            r_fwd_data <= i_wr.data;
        end
    end

    always_comb begin
        for (int r = 0; r < RT_ROWS; r++) begin
            for (int k = 0; k < RT_LANES; k++) begin
                set_mask[r*RT_LANES + k] = (i_wr.row == RT_ROW_W'(r)) && i_wr.be[k];
            end
        end
        n_valid = i_wr.fill ? set_mask : (r_valid | set_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_clear_val <= CHAR_NULL;
        end else if (i_wr.en) begin
            r_valid <= n_valid;
            if (i_wr.fill) begin
                r_clear_val <= CHAR_DOT;
            end
        end
    end

    assign lane     = i_cur_idx[RT_LANE_W-1:0];
    assign mem_char = r_fwd_be[lane] ? r_fwd_data[lane*8 +: 8] : r_rd_data[lane*8 +: 8];
    assign o_char   = r_valid[i_cur_idx] ? mem_char : r_clear_val;

endmodule

FILE: rtl/core/rds_group_decoder_core.sv
// Top level of the RDS group decoder
//
// i_in carries one request per handshake: opcode 0 decodes a group of four
// blocks, opcode 1 reads a programme-service char, opcode 2 a radio-text
// char. o_out returns exactly one result per request, in order, showing
// header, AF, programme item and the char read after that request.
// A request passes the input register, then the result register, before it
// shows on o_out. Throughput: one request per cycle while o_out does not
// stall, set by the row memory port of the text store, which is read when
// the request is taken and forwarded from the write of the request ahead
// of it.
// Reset (synchronous, active low) clears the header, AF pair, item time and
// both char stores; the text store clears through per-char valid bits, so
// there is no clearing pass and requests are taken right after reset.
// When o_out stalls the result register holds, the input register still
// fills once, and i_in.ready drops only when both are full.
`timescale 1ns / 1ps
module rds_group_decoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgd_in_if.sink        i_in,
    rgd_out_if.source     o_out
);
    import rgd_pkg::*;

    logic       r_in_valid;
    t_in_req    r_in;
    logic       r_out_valid;
    t_out_req   r_out;

    logic [7:0]  r_ps [NAME_LEN];
    logic [1:0]  r_ab_last;
    logic [15:0] r_af;
    logic [15:0] r_time;
    logic [15:0] r_pi;
    logic        r_tp;
    logic [4:0]  r_pty;
    logic [4:0]  r_grp;

    logic [15:0] n_af;
    logic [15:0] n_time;
    logic [15:0] n_pi;
    logic        n_tp;
    logic [4:0]  n_pty;
    logic [4:0]  n_grp;
    logic [7:0]  n_char;

    logic    adv;
    logic    commit;
    logic    in_acc;
    t_dec    dec;
    t_rt_wr  rt_wr;
    logic [7:0] rt_char;
    logic [NAME_IDX_W-1:0] ps_lo;
    logic [NAME_IDX_W-1:0] ps_hi;

    assign adv          = !r_out_valid || o_out.ready;
    assign commit       = r_in_valid && adv;
    assign i_in.ready   = !r_in_valid || adv;
    assign in_acc       = i_in.valid && i_in.ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out;

    rgd_decode u_decode (
        .i_req     (r_in),
        .i_ab_last (r_ab_last),
        .o_dec     (dec)
    );

    always_comb begin
        rt_wr      = dec.rt;
        rt_wr.en   = dec.rt.en && commit;
        rt_wr.fill = dec.rt.fill && commit;
    end

    rgd_text_store u_text_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (rt_wr),
        .i_rd_en   (in_acc),
        .i_rd_idx  (i_in.data.read_index),
        .i_cur_idx (r_in.read_index),
        .o_char    (rt_char)
    );

    assign n_pi   = dec.hdr_en  ? r_in.block_a          : r_pi;
    assign n_tp   = dec.hdr_en  ? r_in.block_b[10]      : r_tp;
    assign n_pty  = dec.hdr_en  ? r_in.block_b[9:5]     : r_pty;
    assign n_grp  = dec.hdr_en  ? r_in.block_b[15:11]   : r_grp;
    assign n_af   = dec.af_en   ? r_in.block_c          : r_af;
    assign n_time = dec.time_en ? r_in.block_d          : r_time;
    assign ps_lo  = {dec.ps_seg, 1'b0};
    assign ps_hi  = {dec.ps_seg, 1'b1};

    always_comb begin
        case (r_in.opcode)
            OP_READ_PS: begin
                n_char = (r_in.read_index[5:NAME_IDX_W] == '0)
                         ? r_ps[r_in.read_index[NAME_IDX_W-1:0]] : CHAR_NULL;
            end
            OP_READ_RT: n_char = rt_char;
            default:    n_char = CHAR_NULL;
        endcase
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in.data;
        end
        if (commit) begin
            r_out.prog_ident      <= n_pi;
            r_out.traffic_prog    <= n_tp;
            r_out.prog_type       <= n_pty;
            r_out.group_code      <= n_grp;
            r_out.alt_freq_first  <= n_af[15:8];
            r_out.alt_freq_second <= n_af[7:0];
            r_out.item_day        <= n_time[15:11];
            r_out.item_hour       <= n_time[10:6];
            r_out.item_minute     <= n_time[5:0];
            r_out.read_char       <= n_char;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NAME_LEN; i++) begin
                r_ps[i] <= CHAR_NULL;
            end
            r_ab_last <= AB_NONE;
            r_af      <= '0;
            r_time    <= '0;
            r_pi      <= '0;
            r_tp      <= 1'b0;
            r_pty     <= '0;
            r_grp     <= '0;
        end else if (commit) begin
            r_af   <= n_af;
            r_time <= n_time;
            r_pi   <= n_pi;
            r_tp   <= n_tp;
            r_pty  <= n_pty;
            r_grp  <= n_grp;
            if (dec.ps_en) begin
                r_ps[ps_lo] <= r_in.block_d[15:8];
                r_ps[ps_hi] <= r_in.block_d[7:0];
            end
            if (dec.rt.fill) begin
                r_ab_last <= {1'b0, r_in.block_b[4]};
            end
        end
    end

    // every committed request must produce a result next cycle
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("committed request produced no result");

    // a text group leaves the last A/B flag equal to its own flag
    a_ab_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && dec.rt.en) |=> (r_ab_last == {1'b0, $past(r_in.block_b[4])}))
        else $error("A/B flag not tracked after text group");

    // out-of-range PS read returns zero
    a_ps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_in.opcode == OP_READ_PS) && (r_in.read_index[5:NAME_IDX_W] != '0))
        |=> (r_out.read_char == CHAR_NULL))
        else $error("PS read beyond name length returned nonzero");

    // reads leave the header untouched
    a_read_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_in.opcode != OP_DECODE)) |=> $stable(r_pi) && $stable(r_grp))
        else $error("read request changed the header");

endmodule
